// ===== design/rrts_pkg.sv =====
// Shared types and constants for the round-robin thread scheduler.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package rrts_pkg;

	localparam int SLOTS = 128;
	localparam int IDW = $clog2(SLOTS);
	localparam int CNTW = $clog2(SLOTS + 1);
	localparam int FIELD_W = 7;
	localparam logic [FIELD_W-1:0] LIMIT_RESET = 7'd100;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_EXIT   = 2'd1,
		OP_YIELD  = 2'd2,
		OP_JOIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RC_OK        = 2'd0,
		RC_LIMIT     = 2'd1,
		RC_NOT_READY = 2'd2
	} res_code_t;

	typedef enum logic [1:0] {
		ST_INACTIVE = 2'd0,
		ST_READY    = 2'd1,
		ST_WAIT     = 2'd2,
		ST_MAIN     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_JOIN,
		S_SCAN,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic           en;
		logic [IDW-1:0] addr;
		status_t        data;
	} status_wr_t;

	typedef struct packed {
		logic           en;
		logic [IDW-1:0] addr;
		logic [IDW-1:0] data;
	} wait_wr_t;

endpackage

// ===== design/rrts_status_mem.sv =====
// Thread status store: one write port, two registered read ports.
// Slots above the created count read inactive; slot 0 reads main until first written.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_status_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rrts_pkg::IDW-1:0]   created,
	input  rrts_pkg::status_wr_t       wr,
	input  logic [rrts_pkg::IDW-1:0]   rd_a_addr,
	input  logic [rrts_pkg::IDW-1:0]   rd_b_addr,
	output rrts_pkg::status_t          rd_a_data,
	output rrts_pkg::status_t          rd_b_data
);
	import rrts_pkg::*;

	status_t mem [SLOTS];
	status_t rd_a_q;
	status_t rd_b_q;
	logic    a_over_q;
	logic    b_over_q;
	logic    a_main_q;
	logic    b_main_q;
	logic    main_written_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_a_q   <= mem[rd_a_addr];
		rd_b_q   <= mem[rd_b_addr];
		a_over_q <= rd_a_addr > created;
		b_over_q <= rd_b_addr > created;
		a_main_q <= (rd_a_addr == '0) && !main_written_q;
		b_main_q <= (rd_b_addr == '0) && !main_written_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_written_q <= 1'b0;
		end else if (wr.en && wr.addr == '0) begin
			main_written_q <= 1'b1;
		end
	end

	assign rd_a_data = a_over_q ? ST_INACTIVE : (a_main_q ? ST_MAIN : rd_a_q);
	assign rd_b_data = b_over_q ? ST_INACTIVE : (b_main_q ? ST_MAIN : rd_b_q);

endmodule

// ===== design/rrts_wait_mem.sv =====
// Waited-on thread store: one write port, one registered read port.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_wait_mem (
	input  logic                     clk,
	input  rrts_pkg::wait_wr_t       wr,
	input  logic [rrts_pkg::IDW-1:0] rd_addr,
	output logic [rrts_pkg::IDW-1:0] rd_data
);
	import rrts_pkg::*;

	logic [IDW-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/round_robin_thread_scheduler.sv =====
// Round-robin thread scheduler: control, scan pipeline and result register.
// One item at a time; the next transfer is taken the cycle after the output register
// loads, which waits on m_axis_tready while the output register is still full.
// Create goes through the result register to the output register; join reads the
// target's status first; yield and exit scan the ring for a ready slot and report idle
// when none is; the ring scan reads one slot per cycle from the status memory (s1/s2 read pipeline).
// Reset: slot 0 main, all others inactive, limit 100; no clearing pass needed.
// Depends on rrts_pkg, rrts_status_mem, rrts_wait_mem.
`timescale 1ns / 1ps

module round_robin_thread_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,       // thread_limit
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [6:0] target_id, [7] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [6:0] switch_to, [13:7] new_id, [15:14] zero
	output logic [2:0]  m_axis_tuser    // [1:0] result_code, [2] idle
);
	import rrts_pkg::*;

	fsm_t                 state_q, state_d;
	logic [FIELD_W-1:0]   limit_q;
	logic [IDW-1:0]       cc_q;
	logic [IDW-1:0]       run_slot_q;
	logic                 run_valid_q;
	logic [IDW-1:0]       target_q;
	logic                 target_ok_q;
	logic [IDW-1:0]       ptr_q;
	logic [CNTW-1:0]      left_q;
	logic                 v_s1, v_s2;
	logic [IDW-1:0]       slot_s1, slot_s2;
	status_t              st_s2;

	res_code_t            res_code_q;
	logic [IDW-1:0]       res_sw_q;
	logic                 res_idle_q;
	logic [IDW-1:0]       res_new_q;
	logic                 out_valid_q;
	res_code_t            out_code_q;
	logic [FIELD_W-1:0]   out_sw_q;
	logic                 out_idle_q;
	logic [FIELD_W-1:0]   out_new_q;

	status_wr_t           st_wr;
	wait_wr_t             wt_wr;
	logic [IDW-1:0]       rd_a_addr;
	status_t              st_a, st_b;
	logic [IDW-1:0]       waited;

	logic                 accept;
	op_t                  op_in;
	logic [IDW-1:0]       cur;
	logic [IDW-1:0]       cc_next;
	logic                 create_fail;
	logic                 join_ok;
	logic                 hit;
	logic                 drained;
	logic                 issue;
	logic                 scan_init;
	logic                 cc_inc;
	logic                 ld_res;
	logic                 run_ld;
	logic [IDW-1:0]       run_slot_d;
	logic                 run_valid_d;
	res_code_t            res_code_d;
	logic [IDW-1:0]       res_sw_d;
	logic                 res_idle_d;
	logic [IDW-1:0]       res_new_d;
	logic                 out_ld;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op_in         = op_t'(s_axis_tuser);
	assign cur           = run_valid_q ? run_slot_q : '0;
	assign cc_next       = cc_q + IDW'(1);
	assign create_fail   = (int'(cc_q) >= int'(limit_q)) || (int'(cc_q) + 1 >= SLOTS);
	assign join_ok       = target_ok_q && (st_a == ST_READY);

	// stage 2 decides the oldest slot in flight; a waiting thread needs its target inactive
	assign hit     = v_s2 && ((st_s2 == ST_READY) || (st_s2 == ST_WAIT && st_b == ST_INACTIVE));
	assign drained = (left_q == '0) && !v_s1 && !v_s2;

	assign rd_a_addr = (state_q == S_SCAN) ? ptr_q : IDW'(s_axis_tdata[6:0]);

	rrts_status_mem u_status (
		.clk       (clk),
		.arst_n    (arst_n),
		.created   (cc_q),
		.wr        (st_wr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (waited),
		.rd_a_data (st_a),
		.rd_b_data (st_b)
	);

	rrts_wait_mem u_wait (
		.clk     (clk),
		.wr      (wt_wr),
		.rd_addr (rd_a_addr),
		.rd_data (waited)
	);

	always_comb begin
		state_d     = state_q;
		issue       = 1'b0;
		scan_init   = 1'b0;
		cc_inc      = 1'b0;
		ld_res      = 1'b0;
		run_ld      = 1'b0;
		run_slot_d  = cur;
		run_valid_d = run_valid_q;
		res_code_d  = RC_OK;
		res_sw_d    = cur;
		res_idle_d  = 1'b0;
		res_new_d   = '0;
		out_ld      = 1'b0;
		st_wr       = '{en: 1'b0, addr: '0, data: ST_INACTIVE};
		wt_wr       = '{en: 1'b0, addr: '0, data: '0};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_in)
						OP_CREATE: begin
							ld_res = 1'b1;
							if (create_fail) begin
								res_code_d = RC_LIMIT;
							end else begin
								cc_inc    = 1'b1;
								res_new_d = cc_next;
								st_wr     = '{en: 1'b1, addr: cc_next, data: ST_READY};
							end
							state_d = S_DONE;
						end
						OP_EXIT: begin
							st_wr     = '{en: 1'b1, addr: cur, data: ST_INACTIVE};
							scan_init = 1'b1;
							state_d   = S_SCAN;
						end
						OP_YIELD: begin
							scan_init = 1'b1;
							state_d   = S_SCAN;
						end
						OP_JOIN: begin
							state_d = S_JOIN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_JOIN: begin
				ld_res = 1'b1;
				if (join_ok) begin
					st_wr       = '{en: 1'b1, addr: cur, data: ST_WAIT};
					wt_wr       = '{en: 1'b1, addr: cur, data: target_q};
					run_ld      = 1'b1;
					run_slot_d  = target_q;
					run_valid_d = 1'b1;
					res_sw_d    = target_q;
				end else begin
					res_code_d = RC_NOT_READY;
				end
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (hit) begin
					if (st_s2 == ST_WAIT) begin
						st_wr = '{en: 1'b1, addr: slot_s2, data: ST_READY};
					end
					ld_res      = 1'b1;
					res_sw_d    = slot_s2;
					run_ld      = 1'b1;
					run_slot_d  = slot_s2;
					run_valid_d = 1'b1;
					state_d     = S_DONE;
				end else if (drained) begin
					ld_res      = 1'b1;
					res_sw_d    = '0;
					res_idle_d  = 1'b1;
					run_ld      = 1'b1;
					run_slot_d  = '0;
					run_valid_d = 1'b0;
					state_d     = S_DONE;
				end else begin
					issue = (left_q != '0);
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= LIMIT_RESET;
			cc_q        <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
			left_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (cc_inc) begin
				cc_q <= cc_next;
			end
			if (run_ld) begin
				run_slot_q  <= run_slot_d;
				run_valid_q <= run_valid_d;
			end
			// ring holds created_count + 1 slots
			if (scan_init) begin
				left_q <= CNTW'(cc_q) + CNTW'(1);
			end else if (issue) begin
				left_q <= left_q - CNTW'(1);
			end
			if (state_q == S_SCAN && !hit) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
			end else begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q    <= IDW'(s_axis_tdata[6:0]);
			target_ok_q <= int'(s_axis_tdata[6:0]) < SLOTS;
		end
		if (scan_init) begin
			ptr_q <= (cur == cc_q) ? '0 : cur + IDW'(1);
		end else if (issue) begin
			ptr_q <= (ptr_q == cc_q) ? '0 : ptr_q + IDW'(1);
		end
		slot_s1 <= ptr_q;
		slot_s2 <= slot_s1;
		st_s2   <= st_a;
		if (ld_res) begin
			res_code_q <= res_code_d;
			res_sw_q   <= res_sw_d;
			res_idle_q <= res_idle_d;
			res_new_q  <= res_new_d;
		end
		if (out_ld) begin
			out_code_q <= res_code_q;
			out_sw_q   <= FIELD_W'(res_sw_q);
			out_idle_q <= res_idle_q;
			out_new_q  <= FIELD_W'(res_new_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_new_q, out_sw_q};
	assign m_axis_tuser  = {out_idle_q, out_code_q};

endmodule
